[rtl/wis_pkg.sv]
// Shared types and constants of the weighted index sampler.
// Field widths, operation and status codes, cell commands and the state type.
// No dependencies; every other file takes its names from here.
`timescale 1ns / 1ps

package wis_pkg;

    // Field widths of one beat on either side.
    localparam int KindW   = 3;
    localparam int IndexW  = 10;
    localparam int WeightW = 17;
    localparam int RandW   = 26;
    localparam int StatusW = 3;
    localparam int PrefixW = 27;
    localparam int CountW  = 11;

    // Packed bus widths, filled up to whole bytes.
    localparam int InDataW  = 56;
    localparam int OutDataW = 72;

    // Operation codes carried on the slave-side tuser.
    localparam logic [KindW-1:0] KIND_APPEND = 3'd0;
    localparam logic [KindW-1:0] KIND_CHANGE = 3'd1;
    localparam logic [KindW-1:0] KIND_RECOMP = 3'd2;
    localparam logic [KindW-1:0] KIND_DRAW   = 3'd3;
    localparam logic [KindW-1:0] KIND_POP    = 3'd4;

    // Result status codes.
    localparam logic [StatusW-1:0] ST_OK     = 3'd0;
    localparam logic [StatusW-1:0] ST_FULL   = 3'd1;
    localparam logic [StatusW-1:0] ST_EMPTY  = 3'd2;
    localparam logic [StatusW-1:0] ST_INDEX  = 3'd3;
    localparam logic [StatusW-1:0] ST_STALE  = 3'd4;
    localparam logic [StatusW-1:0] ST_RANDOM = 3'd5;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP,
        CMD_WRITE,
        CMD_SUM,
        CMD_MARK,
        CMD_SHIFT
    } t_cmd;

    // One table entry as held in a cell.
    typedef struct packed {
        logic [WeightW-1:0] weight;
        logic [PrefixW-1:0] prefix;
    } t_entry;

    // Control group shared by all cells.
    typedef struct packed {
        t_cmd               cmd;
        logic [WeightW-1:0] weight;
        logic [RandW-1:0]   draw_value;
    } t_cell_ctrl;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAVE,
        S_DONE
    } t_state;

endpackage

[rtl/weighted_index_sampler.sv]
// Weighted index sampler. An accepted input beat passes the S_EXEC and S_DONE states, and
// its result beat is registered on leaving S_DONE; recompute and a searching draw add an
// S_WAVE pass that steps one cell per cycle over the held entries. One operation is in
// flight at a time: beats are taken only in S_IDLE; a waiting result holds the sequencer.
// Synchronous active-low reset empties the table, marks the sums valid and drops the output
// beat; entry contents stay undefined until written. Depends on wis_pkg and wis_chain.
`timescale 1ns / 1ps

module weighted_index_sampler #(
    parameter int              DEPTH        = 1024,
    parameter longint unsigned WEIGHT_LIMIT = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // entry_index, weight_value, random_value (from bit 0 up), zero fill
    input  logic [wis_pkg::InDataW-1:0]  s_axis_tdata,
    // kind
    input  logic [wis_pkg::KindW-1:0]    s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status, picked_index, popped_weight, total_weight, entry_count (from bit 0 up),
    // zero fill
    output logic [wis_pkg::OutDataW-1:0] m_axis_tdata
);

    localparam int IdxW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam int CmpW = (CntW > wis_pkg::IndexW + 1) ? CntW : wis_pkg::IndexW + 1;
    localparam int OutUsedW = wis_pkg::StatusW + wis_pkg::IndexW + wis_pkg::WeightW
                            + wis_pkg::PrefixW + wis_pkg::CountW;
    localparam logic [32:0] LimitW = 33'(WEIGHT_LIMIT);

    // Input field offsets within tdata.
    localparam int WOff = wis_pkg::IndexW;
    localparam int ROff = WOff + wis_pkg::WeightW;

    // Control state.
    wis_pkg::t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count;
    logic            r_sums_ok, n_sums_ok;
    logic            r_m_valid, n_m_valid;

    // Operation payload.
    logic [wis_pkg::KindW-1:0]   r_kind, n_kind;
    logic [wis_pkg::WeightW-1:0] r_w, n_w;
    logic [wis_pkg::RandW-1:0]   r_r, n_r;
    logic [IdxW-1:0]             r_pos, n_pos;
    logic                        r_idx_bad, n_idx_bad;
    logic [CntW-1:0]             r_step, n_step;
    logic [IdxW-1:0]             r_kmax, n_kmax;
    logic [wis_pkg::StatusW-1:0] r_status, n_status;
    logic [wis_pkg::IndexW-1:0]  r_pick, n_pick;
    logic [wis_pkg::WeightW-1:0] r_pop, n_pop;
    logic [wis_pkg::OutDataW-1:0] r_m_data, n_m_data;

    // Input fields and derived values.
    logic [wis_pkg::IndexW-1:0]  in_idx;
    logic [wis_pkg::WeightW-1:0] in_w;
    logic [wis_pkg::WeightW-1:0] in_w_sat;
    logic [wis_pkg::RandW-1:0]   in_r;
    logic [CmpW-1:0]             ext_cnt;
    logic [CmpW-1:0]             ext_idx;
    logic [IdxW-1:0]             kmax_now;
    logic                        wave_last;
    logic [wis_pkg::PrefixW-1:0] last_prefix;

    wis_pkg::t_cell_ctrl ctrl;
    wis_pkg::t_entry     head;
    wis_pkg::t_entry     top_ent;
    logic                top_flag;

    // Field extraction and weight saturation.
    assign in_idx   = s_axis_tdata[wis_pkg::IndexW-1:0];
    assign in_w     = s_axis_tdata[WOff +: wis_pkg::WeightW];
    assign in_r     = s_axis_tdata[ROff +: wis_pkg::RandW];
    assign in_w_sat = (33'(in_w) > LimitW) ? LimitW[wis_pkg::WeightW-1:0] : in_w;
    assign ext_cnt  = CmpW'(r_count);
    assign ext_idx  = CmpW'(in_idx);

    // Stored prefix of the newest entry, zero when empty.
    assign last_prefix = (r_count == '0) ? '0 : top_ent.prefix;

    // Entry pushed into cell 0 on append.
    assign head.weight = r_w;
    assign head.prefix = last_prefix + wis_pkg::PrefixW'(r_w);

    // Search bookkeeping: the deepest cell above the draw value wins.
    assign kmax_now  = top_flag ? r_step[IdxW-1:0] : r_kmax;
    assign wave_last = (r_step == r_count - CntW'(1));

    assign s_axis_tready = (r_state == wis_pkg::S_IDLE);

    // Sequencer: next state, cell commands and result fields.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sums_ok = r_sums_ok;
        n_m_valid = r_m_valid;
        n_kind    = r_kind;
        n_w       = r_w;
        n_r       = r_r;
        n_pos     = r_pos;
        n_idx_bad = r_idx_bad;
        n_step    = r_step;
        n_kmax    = r_kmax;
        n_status  = r_status;
        n_pick    = r_pick;
        n_pop     = r_pop;
        n_m_data  = r_m_data;

        ctrl.cmd        = wis_pkg::CMD_HOLD;
        ctrl.weight     = r_w;
        ctrl.draw_value = r_r;

        // The result beat leaves when taken.
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            wis_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_kind    = s_axis_tuser;
                    n_w       = in_w_sat;
                    n_r       = in_r;
                    n_idx_bad = (ext_idx >= ext_cnt);
                    if (s_axis_tuser == wis_pkg::KIND_CHANGE) begin
                        n_pos = IdxW'(ext_cnt - ext_idx - CmpW'(1));
                    end else begin
                        n_pos = IdxW'(r_count - CntW'(1));
                    end
                    n_step   = '0;
                    n_kmax   = '0;
                    n_status = wis_pkg::ST_OK;
                    n_pick   = '0;
                    n_pop    = '0;
                    n_state  = wis_pkg::S_EXEC;
                end
            end

            wis_pkg::S_EXEC: begin
                n_state = wis_pkg::S_DONE;
                unique case (r_kind)
                    wis_pkg::KIND_APPEND: begin
                        if (r_count == CntW'(DEPTH)) begin
                            n_status = wis_pkg::ST_FULL;
                        end else begin
                            ctrl.cmd = wis_pkg::CMD_PUSH;
                            n_count  = r_count + CntW'(1);
                        end
                    end
                    wis_pkg::KIND_CHANGE: begin
                        if (r_idx_bad) begin
                            n_status = wis_pkg::ST_INDEX;
                        end else begin
                            ctrl.cmd  = wis_pkg::CMD_WRITE;
                            n_sums_ok = 1'b0;
                        end
                    end
                    wis_pkg::KIND_RECOMP: begin
                        n_sums_ok = 1'b1;
                        if (r_count != '0) begin
                            n_state = wis_pkg::S_WAVE;
                        end
                    end
                    wis_pkg::KIND_DRAW: begin
                        if (r_count == '0) begin
                            n_status = wis_pkg::ST_EMPTY;
                        end else if (!r_sums_ok) begin
                            n_status = wis_pkg::ST_STALE;
                        end else if (top_ent.prefix == '0) begin
                            // Zero total: the draw value is the index itself.
                            if (wis_pkg::PrefixW'(r_r) >= wis_pkg::PrefixW'(r_count)) begin
                                n_status = wis_pkg::ST_RANDOM;
                            end else begin
                                n_pick = wis_pkg::IndexW'(r_r);
                            end
                        end else if (wis_pkg::PrefixW'(r_r) >= top_ent.prefix) begin
                            n_status = wis_pkg::ST_RANDOM;
                        end else begin
                            ctrl.cmd = wis_pkg::CMD_MARK;
                            n_state  = wis_pkg::S_WAVE;
                        end
                    end
                    wis_pkg::KIND_POP: begin
                        if (r_count == '0) begin
                            n_status = wis_pkg::ST_EMPTY;
                        end else begin
                            n_pop    = top_ent.weight;
                            ctrl.cmd = wis_pkg::CMD_POP;
                            n_count  = r_count - CntW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            wis_pkg::S_WAVE: begin
                // One step of the running sum or of the flag scan per cycle.
                if (r_kind == wis_pkg::KIND_RECOMP) begin
                    ctrl.cmd = wis_pkg::CMD_SUM;
                end else begin
                    ctrl.cmd = wis_pkg::CMD_SHIFT;
                    n_kmax   = kmax_now;
                    n_pick   = wis_pkg::IndexW'(r_count - CntW'(1) - CntW'(kmax_now));
                end
                n_step = r_step + CntW'(1);
                if (wave_last) begin
                    n_state = wis_pkg::S_DONE;
                end
            end

            wis_pkg::S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{(wis_pkg::OutDataW - OutUsedW){1'b0}},
                                 wis_pkg::CountW'(r_count),
                                 last_prefix,
                                 r_pop,
                                 r_pick,
                                 r_status};
                    n_state   = wis_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = wis_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wis_pkg::S_IDLE;
            r_count   <= '0;
            r_sums_ok <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_sums_ok <= n_sums_ok;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_w       <= n_w;
        r_r       <= n_r;
        r_pos     <= n_pos;
        r_idx_bad <= n_idx_bad;
        r_step    <= n_step;
        r_kmax    <= n_kmax;
        r_status  <= n_status;
        r_pick    <= n_pick;
        r_pop     <= n_pop;
        r_m_data  <= n_m_data;
    end

    wis_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_pos   (r_pos),
        .i_head  (head),
        .o_top   (top_ent),
        .o_flag0 (top_flag)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

[rtl/wis_cell.sv]
// One cell of the sampler row: holds one entry and a search flag.
// Depends on wis_pkg for the entry, control and command types.
`timescale 1ns / 1ps

module wis_cell (
    input  logic                i_clk,
    input  wis_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_sel,
    input  wis_pkg::t_entry     i_up,
    input  wis_pkg::t_entry     i_dn,
    input  logic                i_dn_flag,
    output wis_pkg::t_entry     o_ent,
    output logic                o_flag
);

    wis_pkg::t_entry r_ent;
    wis_pkg::t_entry n_ent;
    logic            r_flag;
    logic            n_flag;

    // Decode the broadcast command for this cell.
    always_comb begin
        n_ent  = r_ent;
        n_flag = r_flag;
        unique case (i_ctrl.cmd)
            wis_pkg::CMD_HOLD: begin
            end
            wis_pkg::CMD_PUSH: begin
                n_ent = i_up;
            end
            wis_pkg::CMD_POP: begin
                n_ent = i_dn;
            end
            wis_pkg::CMD_WRITE: begin
                if (i_sel) begin
                    n_ent.weight = i_ctrl.weight;
                end
            end
            wis_pkg::CMD_SUM: begin
                // The oldest entry starts the running sum from zero.
                n_ent.prefix = (i_sel ? {wis_pkg::PrefixW{1'b0}} : i_dn.prefix)
                             + wis_pkg::PrefixW'(r_ent.weight);
            end
            wis_pkg::CMD_MARK: begin
                n_flag = r_ent.prefix > wis_pkg::PrefixW'(i_ctrl.draw_value);
            end
            wis_pkg::CMD_SHIFT: begin
                n_flag = i_dn_flag;
            end
            default: begin
            end
        endcase
    end

    // Entry and flag are payload; they carry no reset.
    always_ff @(posedge i_clk) begin
        r_ent  <= n_ent;
        r_flag <= n_flag;
    end

    assign o_ent  = r_ent;
    assign o_flag = r_flag;

endmodule

[rtl/wis_chain.sv]
// Row of sampler cells; cell 0 holds the newest entry, deeper cells older ones.
// Depends on wis_pkg and wis_cell.
`timescale 1ns / 1ps

module wis_chain #(
    parameter int DEPTH = 1024
) (
    input  logic                    i_clk,
    input  wis_pkg::t_cell_ctrl     i_ctrl,
    input  logic [$clog2(DEPTH)-1:0] i_pos,
    input  wis_pkg::t_entry         i_head,
    output wis_pkg::t_entry         o_top,
    output logic                    o_flag0
);

    localparam int IdxW = $clog2(DEPTH);

    wis_pkg::t_entry ent    [DEPTH];
    wis_pkg::t_entry up_ent [DEPTH];
    wis_pkg::t_entry dn_ent [DEPTH];
    logic            flag   [DEPTH];
    logic            dn_flag[DEPTH];
    logic            sel    [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        // Neighbor wiring: the head feeds cell 0, zeros feed the deepest cell.
        if (k == 0) begin : g_first
            assign up_ent[k] = i_head;
        end else begin : g_mid_up
            assign up_ent[k] = ent[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign dn_ent[k]  = '0;
            assign dn_flag[k] = 1'b0;
        end else begin : g_mid_dn
            assign dn_ent[k]  = ent[k+1];
            assign dn_flag[k] = flag[k+1];
        end

        // Position decoder for weight writes and the start of the running sum.
        assign sel[k] = (i_pos == IdxW'(k));

        wis_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (i_ctrl),
            .i_sel     (sel[k]),
            .i_up      (up_ent[k]),
            .i_dn      (dn_ent[k]),
            .i_dn_flag (dn_flag[k]),
            .o_ent     (ent[k]),
            .o_flag    (flag[k])
        );
    end

    assign o_top   = ent[0];
    assign o_flag0 = flag[0];

endmodule

[rtl/wis_check.sv]
// Port-level checker for the weighted index sampler, bound to the top level.
// Depends on wis_pkg for the bus widths and status codes.
`timescale 1ns / 1ps

module wis_check #(
    parameter int DEPTH = 1024
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [wis_pkg::OutDataW-1:0] m_axis_tdata
);

    localparam int PickOff  = wis_pkg::StatusW;
    localparam int PopOff   = PickOff + wis_pkg::IndexW;
    localparam int CountOff = PopOff + wis_pkg::WeightW + wis_pkg::PrefixW;

    logic [wis_pkg::StatusW-1:0] m_status;
    logic [wis_pkg::IndexW-1:0]  m_pick;
    logic [wis_pkg::WeightW-1:0] m_pop;
    logic [wis_pkg::CountW-1:0]  m_count;

    assign m_status = m_axis_tdata[wis_pkg::StatusW-1:0];
    assign m_pick   = m_axis_tdata[PickOff +: wis_pkg::IndexW];
    assign m_pop    = m_axis_tdata[PopOff +: wis_pkg::WeightW];
    assign m_count  = m_axis_tdata[CountOff +: wis_pkg::CountW];

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // One operation at a time: an accepted beat closes the input until it is done.
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an operation was in flight");

    // The reported count never exceeds the table depth.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_count) <= DEPTH)
        else $error("entry count above depth");

    // A picked index or a popped weight only comes with a good status, never both.
    a_pick_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_pick != '0 || m_pop != '0)
        |-> m_status == wis_pkg::ST_OK && (m_pick == '0 || m_pop == '0))
        else $error("picked index or popped weight on a failed or mixed result");

endmodule

bind weighted_index_sampler wis_check #(
    .DEPTH (DEPTH)
) u_wis_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/tb_top.sv]
// Self-checking bench for the weighted index sampler: drives append, change, recompute,
// draw and pop beats in random bursts and checks every result beat against a scoreboard.
// Depends on wis_pkg and weighted_index_sampler.
`timescale 1ns / 1ps

module tb_top;

    localparam int Depth       = 1024;
    localparam int WeightLimit = 65536;
    localparam int RandomItems = 80;
    localparam int TailPops    = 16;
    localparam int CycleLimit  = 2000000;
    localparam int DrainCycles = 40;

    // Kinds the block decodes as no operation.
    localparam logic [wis_pkg::KindW-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [wis_pkg::KindW-1:0] KIND_UNUSED_HI = 3'd7;

    // Bit offsets of the result fields in the master-side tdata.
    localparam int PickLo  = wis_pkg::StatusW;
    localparam int PopLo   = PickLo + wis_pkg::IndexW;
    localparam int TotalLo = PopLo + wis_pkg::WeightW;
    localparam int CountLo = TotalLo + wis_pkg::PrefixW;

    typedef struct {
        logic [wis_pkg::KindW-1:0]   kind;
        logic [wis_pkg::IndexW-1:0]  idx;
        logic [wis_pkg::WeightW-1:0] weight;
        logic [wis_pkg::RandW-1:0]   rnd;
    } t_op;

    typedef struct {
        logic [wis_pkg::StatusW-1:0] status;
        logic [wis_pkg::IndexW-1:0]  picked;
        logic [wis_pkg::WeightW-1:0] popped;
        logic [wis_pkg::PrefixW-1:0] total;
        logic [wis_pkg::CountW-1:0]  count;
    } t_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_MASK,
        RX_COIN
    } t_rx_mode;

    // Mirror of the weight table; predicts one result per accepted operation.
    class sampler_scoreboard;
        logic [wis_pkg::WeightW-1:0] weights [Depth];
        logic [wis_pkg::PrefixW-1:0] prefixes [Depth];
        int unsigned                 held;
        bit                          sums_ok;
        t_result                     expected_q [$];
        int unsigned                 errors;

        function new();
            held    = 0;
            sums_ok = 1'b1;
            errors  = 0;
        endfunction

        function logic [wis_pkg::PrefixW-1:0] total_now();
            return (held == 0) ? '0 : prefixes[held-1];
        endfunction

        function void note_op(t_op op);
            t_result                     res;
            logic [wis_pkg::WeightW-1:0] w;
            logic [wis_pkg::PrefixW-1:0] acc;
            logic [wis_pkg::PrefixW-1:0] total;
            int unsigned                 pos;
            res.status = wis_pkg::ST_OK;
            res.picked = '0;
            res.popped = '0;
            // Weights above the limit saturate.
            w = (op.weight > WeightLimit) ? wis_pkg::WeightW'(WeightLimit) : op.weight;
            case (op.kind)
                wis_pkg::KIND_APPEND: begin
                    if (held >= Depth) begin
                        res.status = wis_pkg::ST_FULL;
                    end else begin
                        // Extends the stored last sum, stale or not.
                        weights[held]  = w;
                        prefixes[held] = total_now() + w;
                        held++;
                    end
                end
                wis_pkg::KIND_CHANGE: begin
                    if (op.idx >= held) begin
                        res.status = wis_pkg::ST_INDEX;
                    end else begin
                        weights[op.idx] = w;
                        sums_ok = 1'b0;
                    end
                end
                wis_pkg::KIND_RECOMP: begin
                    acc = '0;
                    for (int i = 0; i < held; i++) begin
                        acc = acc + weights[i];
                        prefixes[i] = acc;
                    end
                    sums_ok = 1'b1;
                end
                wis_pkg::KIND_DRAW: begin
                    total = total_now();
                    if (held == 0) begin
                        res.status = wis_pkg::ST_EMPTY;
                    end else if (!sums_ok) begin
                        res.status = wis_pkg::ST_STALE;
                    end else if (total == 0) begin
                        // All weights zero: the random value is the index itself.
                        if (op.rnd >= held) res.status = wis_pkg::ST_RANDOM;
                        else res.picked = wis_pkg::IndexW'(op.rnd);
                    end else if (op.rnd >= total) begin
                        res.status = wis_pkg::ST_RANDOM;
                    end else begin
                        pos = 0;
                        while (pos < held && prefixes[pos] <= op.rnd) pos++;
                        res.picked = wis_pkg::IndexW'(pos);
                    end
                end
                wis_pkg::KIND_POP: begin
                    if (held == 0) begin
                        res.status = wis_pkg::ST_EMPTY;
                    end else begin
                        held--;
                        res.popped = weights[held];
                    end
                end
                default: begin
                end
            endcase
            res.total = total_now();
            res.count = wis_pkg::CountW'(held);
            expected_q = {expected_q, res};
        endfunction

        function void compare(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [wis_pkg::OutDataW-1:0] beat);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result beat %h with no operation pending, expected none",
                         $time, beat);
                return;
            end
            want = expected_q.pop_front();
            compare("status", want.status, beat[0 +: wis_pkg::StatusW]);
            compare("picked_index", want.picked, beat[PickLo +: wis_pkg::IndexW]);
            compare("popped_weight", want.popped, beat[PopLo +: wis_pkg::WeightW]);
            compare("total_weight", want.total, beat[TotalLo +: wis_pkg::PrefixW]);
            compare("entry_count", want.count, beat[CountLo +: wis_pkg::CountW]);
        endfunction
    endclass

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // entry_index, weight_value, random_value (from bit 0 up), zero fill
    logic [wis_pkg::InDataW-1:0]  s_axis_tdata  = '0;
    // kind
    logic [wis_pkg::KindW-1:0]    s_axis_tuser  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // status, picked_index, popped_weight, total_weight, entry_count (from bit 0 up),
    // zero fill
    logic [wis_pkg::OutDataW-1:0] m_axis_tdata;

    sampler_scoreboard sb;
    int unsigned       burst_left   = 0;
    int unsigned       size_cap     = 8;
    bit                zero_weights = 1'b0;
    int unsigned       cycle_count  = 0;
    t_rx_mode          rx_mode      = RX_ALWAYS;
    logic [7:0]        rx_mask      = 8'hFF;
    int unsigned       rx_tick      = 0;

    weighted_index_sampler DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check each accepted beat, stall on a pattern that changes now and then.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        rx_tick <= rx_tick + 1;
        if (rx_tick % 300 == 299) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_mask <= 8'($urandom) | 8'h01;
        end
        case (rx_mode)
            RX_ALWAYS: m_axis_tready <= 1'b1;
            RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 4) != 0);
            RX_MASK:   m_axis_tready <= rx_mask[rx_tick[2:0]];
            default:   m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    function automatic t_op make_op(logic [wis_pkg::KindW-1:0] kind,
                                    logic [wis_pkg::IndexW-1:0] idx,
                                    logic [wis_pkg::WeightW-1:0] weight,
                                    logic [wis_pkg::RandW-1:0] rnd);
        t_op op;
        op.kind   = kind;
        op.idx    = idx;
        op.weight = weight;
        op.rnd    = rnd;
        return op;
    endfunction

    // Sends one operation beat; a new burst may open with an idle gap.
    task automatic send_op(input t_op op);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.kind;
        s_axis_tdata  <= wis_pkg::InDataW'({op.rnd, op.weight, op.idx});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_op(op);
    endtask

    // Holds the input side idle until every pending result has arrived.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [wis_pkg::WeightW-1:0] pick_weight();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (zero_weights || roll < 10) return '0;
        if (roll < 20) return wis_pkg::WeightW'(WeightLimit);
        if (roll < 30) begin
            return wis_pkg::WeightW'($urandom_range(WeightLimit + 1,
                                                    (1 << wis_pkg::WeightW) - 1));
        end
        if (roll < 40) return wis_pkg::WeightW'($urandom_range(1, 3));
        return wis_pkg::WeightW'($urandom_range(0, WeightLimit));
    endfunction

    // Mostly meaningful operations on a small table, with some noise mixed in.
    function automatic t_op random_op();
        int unsigned     roll;
        longint unsigned total;
        t_op             op;
        roll  = $urandom_range(0, 99);
        total = sb.total_now();
        op = make_op(wis_pkg::KIND_DRAW, wis_pkg::IndexW'($urandom), pick_weight(),
                     wis_pkg::RandW'($urandom));
        if (roll < 30) begin
            op.kind = (sb.held < size_cap) ? wis_pkg::KIND_APPEND : wis_pkg::KIND_POP;
        end else if (roll < 42) begin
            op.kind = wis_pkg::KIND_CHANGE;
            if (sb.held != 0 && $urandom_range(0, 5) != 0)
                op.idx = wis_pkg::IndexW'($urandom_range(0, sb.held - 1));
        end else if (roll < 52) begin
            op.kind = wis_pkg::KIND_RECOMP;
        end else if (roll < 85) begin
            // Stale sums are usually rebuilt before a draw.
            op.kind = (!sb.sums_ok && $urandom_range(0, 2) != 0) ? wis_pkg::KIND_RECOMP
                                                                  : wis_pkg::KIND_DRAW;
            case ($urandom_range(0, 9))
                0: begin
                end
                1: op.rnd = wis_pkg::RandW'((total == 0) ? sb.held : total);
                default: begin
                    if (total != 0)
                        op.rnd = wis_pkg::RandW'($urandom_range(0, 32'(total - 1)));
                    else if (sb.held != 0)
                        op.rnd = wis_pkg::RandW'($urandom_range(0, sb.held - 1));
                end
            endcase
        end else if (roll < 97) begin
            op.kind = wis_pkg::KIND_POP;
        end else begin
            op.kind = wis_pkg::KindW'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end
        return op;
    endfunction

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table corner cases and an unknown kind.
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_POP, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_RECOMP, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_CHANGE, 0, 5, 0));
        send_op(make_op(KIND_UNUSED_HI, 0, 0, 0));
        // Zero total: the random value is returned as the index; one past the last index is refused.
        send_op(make_op(wis_pkg::KIND_APPEND, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_APPEND, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 1));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 2));
        // Saturated weight, then searches at the edges of the total.
        send_op(make_op(wis_pkg::KIND_APPEND, 0, '1, 0));
        send_op(make_op(wis_pkg::KIND_APPEND, 0, 1, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 65536));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 65537));
        // Stale sums: append extends the stored sum, draw refuses.
        send_op(make_op(wis_pkg::KIND_CHANGE, 1, 5, 0));
        send_op(make_op(wis_pkg::KIND_APPEND, 0, 7, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_CHANGE, '1, 9, 0));
        send_op(make_op(wis_pkg::KIND_RECOMP, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 3));
        send_op(make_op(wis_pkg::KIND_POP, 0, 0, 0));
        send_op(make_op(KIND_UNUSED_LO, '1, '1, '1));

        // Random operations in segments of varying table size.
        for (int n = 0; n < RandomItems; n++) begin
            if (n % 20 == 0) begin
                case ($urandom_range(0, 9))
                    0:       size_cap = 0;
                    1:       size_cap = $urandom_range(49, 96);
                    default: size_cap = $urandom_range(1, 24);
                endcase
                zero_weights = ($urandom_range(0, 6) == 0);
                // An all-zero table needs the old entries gone first.
                if (zero_weights)
                    while (sb.held != 0) send_op(make_op(wis_pkg::KIND_POP, 0, 0, 0));
            end
            if (n == RandomItems / 2) wait_drained();
            send_op(random_op());
        end

        // Fill to the full depth, work on the full table, then pop a few entries.
        wait_drained();
        zero_weights = 1'b0;
        while (sb.held != 0) send_op(make_op(wis_pkg::KIND_POP, 0, 0, 0));
        repeat (Depth) begin
            send_op(make_op(wis_pkg::KIND_APPEND, wis_pkg::IndexW'($urandom),
                            ($urandom_range(0, 3) == 0) ? pick_weight()
                                                        : wis_pkg::WeightW'(WeightLimit),
                            wis_pkg::RandW'($urandom)));
        end
        send_op(make_op(wis_pkg::KIND_APPEND, 0, 1, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, '1));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, wis_pkg::RandW'(sb.total_now() - 1)));
        send_op(make_op(wis_pkg::KIND_CHANGE, Depth - 1, pick_weight(), 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_RECOMP, 0, 0, 0));
        send_op(make_op(wis_pkg::KIND_DRAW, 0, 0,
                        wis_pkg::RandW'($urandom_range(0, sb.total_now() - 1))));
        repeat (TailPops) send_op(make_op(wis_pkg::KIND_POP, wis_pkg::IndexW'($urandom), 0, 0));

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
